/* hdl/iatf_pkg.sv */
// ----------------------------------------------------------------------------
// iatf_pkg
// Shared types, constants and the digit-to-ASCII function of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package iatf_pkg;

    // Hex formats print the low HEX_WIDTH bits (32 to 64)
    localparam int HEX_WIDTH  = 64;
    localparam int VALUE_W    = 64;
    localparam int DEC_BITS   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int NIBBLES    = VALUE_W / 4;

    localparam logic [VALUE_W-1:0] HEX_MASK =
        (HEX_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}}
                               : ((VALUE_W'(1) << HEX_WIDTH) - VALUE_W'(1));

    // Action codes
    localparam logic [1:0] ACT_SDEC = 2'd0;
    localparam logic [1:0] ACT_UDEC = 2'd1;
    localparam logic [1:0] ACT_HEXL = 2'd2;
    localparam logic [1:0] ACT_HEXU = 2'd3;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_LOWER = 7'h57;   // 'a' - 10
    localparam logic [6:0] CHAR_UPPER = 7'h37;   // 'A' - 10

    // Classified request handed from front to back
    typedef struct packed {
        logic [1:0]         action;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } cmd_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        if (d < 4'd10)
            base = CHAR_ZERO;
        else if (upper)
            base = CHAR_UPPER;
        else
            base = CHAR_LOWER;
        return base + {3'b000, d};
    endfunction

endpackage

`default_nettype wire

/* hdl/iatf_in_if.sv */
// ----------------------------------------------------------------------------
// iatf_in_if
// Request channel: number to print and its format.
// ----------------------------------------------------------------------------
`default_nettype none

interface iatf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  action;

    modport source (output valid, output value, output action, input ready);
    modport sink   (input valid, input value, input action, output ready);
endinterface

`default_nettype wire

/* hdl/iatf_out_if.sv */
// ----------------------------------------------------------------------------
// iatf_out_if
// Result channel: one ASCII character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface iatf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    logic       last;
    logic [4:0] char_count;

    modport source (output valid, output char_out, output last, output char_count,
                    input ready);
    modport sink   (input valid, input char_out, input last, input char_count,
                    output ready);
endinterface

`default_nettype wire

/* hdl/iatf_front.sv */
// ----------------------------------------------------------------------------
// iatf_front
// Accepts requests, strips sign and masks the value for the chosen format.
// ----------------------------------------------------------------------------
`default_nettype none

module iatf_front (
    iatf_in_if.sink        item,
    input  wire logic      full,
    output logic           push,
    output iatf_pkg::cmd_t cmd
);
    import iatf_pkg::*;

    logic [DEC_BITS-1:0] lo;
    logic                neg;
    logic [DEC_BITS-1:0] lo_mag;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    assign lo     = item.value[DEC_BITS-1:0];
    assign neg    = (item.action == ACT_SDEC) && lo[DEC_BITS-1];
    // two's complement negate; the most negative value maps onto itself
    assign lo_mag = neg ? (~lo + DEC_BITS'(1)) : lo;

    always_comb
    begin
        cmd.action = item.action;
        cmd.neg    = neg;
        if (item.action == ACT_HEXL || item.action == ACT_HEXU)
            cmd.mag = item.value & HEX_MASK;
        else
            cmd.mag = {{(VALUE_W-DEC_BITS){1'b0}}, lo_mag};
    end

endmodule

`default_nettype wire

/* hdl/iatf_fifo.sv */
// ----------------------------------------------------------------------------
// iatf_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module iatf_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire iatf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output iatf_pkg::cmd_t      pop_cmd,
    output logic                empty
);
    import iatf_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

/* hdl/iatf_back.sv */
// ----------------------------------------------------------------------------
// iatf_back
// Converts one request to digits (shift-add-3 for decimal) and emits the
// characters most significant first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iatf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire iatf_pkg::cmd_t pop_cmd,
    output logic                pop,
    iatf_out_if.source          result
);
    import iatf_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SCAN, ST_EMIT} state_t;

    localparam int STEP_W = $clog2(DEC_BITS);
    localparam int BCD_W  = 4 * BCD_DIGITS;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DEC_BITS-1:0] bin_reg;
    logic [VALUE_W-1:0]  dig_reg;
    logic                upper_reg;
    logic                sign_reg;
    logic [3:0]          pos_reg;
    logic [4:0]          total_reg;
    logic                out_valid_reg;
    logic [6:0]          char_reg;
    logic                last_reg;
    logic [4:0]          count_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [VALUE_W-1:0]  dig_next;
    logic [4:0]          ndig;
    logic                out_free;
    logic                emit_fire;
    logic [3:0]          cur_digit;

    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign out_free  = !out_valid_reg || result.ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // one shift-add-3 step over the BCD digits
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = dig_reg[4*i +: 4];
        end
        dig_next = {{(VALUE_W-BCD_W){1'b0}}, bcd_adj[BCD_W-2:0], bin_reg[DEC_BITS-1]};
    end

    // significant digit count, at least one
    always_comb
    begin
        ndig = 5'd1;
        for (int i = 1; i < NIBBLES; i++)
        begin
            if (dig_reg[4*i +: 4] != 4'd0)
                ndig = 5'(i + 1);
        end
    end

    assign cur_digit = dig_reg[{pos_reg, 2'b00} +: 4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            bin_reg       <= '0;
            dig_reg       <= '0;
            upper_reg     <= 1'b0;
            sign_reg      <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        sign_reg  <= pop_cmd.neg;
                        upper_reg <= (pop_cmd.action == ACT_HEXU);
                        bin_reg   <= pop_cmd.mag[DEC_BITS-1:0];
                        step_reg  <= '0;
                        if (pop_cmd.action == ACT_HEXL || pop_cmd.action == ACT_HEXU)
                        begin
                            dig_reg   <= pop_cmd.mag;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            dig_reg   <= '0;
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    dig_reg  <= dig_next;
                    bin_reg  <= {bin_reg[DEC_BITS-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DEC_BITS - 1))
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    pos_reg   <= 4'(ndig - 5'd1);
                    total_reg <= ndig + {4'd0, sign_reg};
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (sign_reg)
                        begin
                            char_reg  <= CHAR_MINUS;
                            last_reg  <= 1'b0;
                            count_reg <= '0;
                            sign_reg  <= 1'b0;
                        end
                        else
                        begin
                            char_reg <= digit_char(cur_digit, upper_reg);
                            pos_reg  <= pos_reg - 4'd1;
                            if (pos_reg == 4'd0)
                            begin
                                last_reg  <= 1'b1;
                                count_reg <= total_reg;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                last_reg  <= 1'b0;
                                count_reg <= '0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.char_out   = char_reg;
    assign result.last       = last_reg;
    assign result.char_count = count_reg;

endmodule

`default_nettype wire

/* hdl/integer_to_ascii_formatter_core.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Prints a number as ASCII text, one character per result transfer.
// ----------------------------------------------------------------------------
// Each request carries a 64-bit value and an action: 0 signed 32-bit decimal,
// 1 unsigned 32-bit decimal, 2 hex lower case, 3 hex upper case (hex over
// the low HEX_WIDTH bits, 64 here). Characters leave most significant first
// with no leading zeros; zero prints as "0", negatives get a leading '-',
// and -2147483648 prints in full. The final character has last set and
// carries the character count; earlier ones carry a count of zero.
// A decimal request is dequeued, converted by shift-add-3 in the back
// end, its leading digit found, then its characters (up to 11) go out
// one per cycle while the sink keeps up with the output register.
// A hex request skips the conversion, with up to 16 characters. The back
// end handles one request at a time; the front end and a two-entry queue
// keep accepting requests while it works, and the output register lets a
// character wait for the sink without holding up the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iatf_in_if.sink    item,
    iatf_out_if.source result
);
    import iatf_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // classify incoming requests
    iatf_front u_front (
        .item (item),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    // decouples request acceptance from character emission
    iatf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    // conversion and emission
    iatf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .result  (result)
    );

    // queue never written when full or read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request queue underflow");

    // count present exactly on the final character
    a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last |-> result.char_count != 5'd0)
        else $error("final character without count");

    a_count_mid: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last |-> result.char_count == 5'd0)
        else $error("count on a non-final character");

endmodule

`default_nettype wire

/* tb/tb_integer_to_ascii_formatter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_core
// Self-checking bench for the integer to ASCII formatter: directed corner
// numbers in every format, then random requests under bursty traffic and a
// stalling result sink. Each character is checked against an in-bench
// formatter.
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_formatter_core;

    import iatf_pkg::*;

    // A transfer-free stretch longer than this means the block is hung. It is
    // many times the slowest correct request, sink stalls and sender gaps
    // included.
    localparam int IDLE_LIMIT   = 4000;
    // Cycles to watch for stray characters after the last expected one
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 112;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;

    // One expected character on the result channel
    typedef struct {
        logic [6:0] char_out;
        logic       last;
        logic [4:0] char_count;
    } text_char_t;

    logic clk;
    logic rst_n;

    iatf_in_if  item_if ();
    iatf_out_if result_if ();

    integer_to_ascii_formatter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    // Characters still owed by the block, oldest first
    text_char_t expected_text[$];
    int         mismatch_count;

    // Sender burst shaping
    int burst_left;
    int gap_len;

    // Receiver stall pattern
    int stall_mode;
    int stall_mode_left;
    int stall_phase;

    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: format one request and queue its characters.
    // ------------------------------------------------------------------------
    function automatic logic [6:0] digit_ascii(input logic [3:0] d, input logic upper);
        if (d < 4'd10)
            return CHAR_ZERO + 7'(d);
        else if (upper)
            return ASCII_UPPER_A + 7'(d) - 7'd10;
        else
            return ASCII_LOWER_A + 7'(d) - 7'd10;
    endfunction

    function automatic void format_number(input logic [63:0] value, input logic [1:0] action);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [31:0] low_word;
        logic        upper;
        logic [6:0]  digits[$];
        logic [6:0]  line[$];
        text_char_t  c;
        int          n;

        low_word = value[31:0];
        upper    = (action == ACT_HEXU);
        case (action)
            ACT_SDEC:
            begin
                radix = 64'd10;
                mag   = {32'd0, low_word};
                if (low_word[31])
                begin
                    line.push_back(CHAR_MINUS);
                    // Two's complement negate; the most negative value maps
                    // onto itself, which is its own magnitude when unsigned.
                    mag = {32'd0, -low_word};
                end
            end
            ACT_UDEC:
            begin
                radix = 64'd10;
                mag   = {32'd0, low_word};
            end
            default:
            begin
                radix = 64'd16;
                mag   = value & HEX_MASK;
            end
        endcase

        // Least significant digit first, so build the digit string backwards
        do
        begin
            digits.push_front(digit_ascii(4'(mag % radix), upper));
            mag = mag / radix;
        end
        while (mag != 64'd0);

        foreach (digits[i])
            line.push_back(digits[i]);

        n = line.size();
        foreach (line[i])
        begin
            c.char_out   = line[i];
            c.last       = (i == n - 1);
            c.char_count = c.last ? 5'(n) : 5'd0;
            expected_text.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted character against the oldest expected.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character 0x%02h last=%0b count=%0d", $time,
                         result_if.char_out, result_if.last, result_if.char_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (result_if.char_out !== want.char_out)
                begin
                    $display("%0t: char_out expected 0x%02h actual 0x%02h", $time,
                             want.char_out, result_if.char_out);
                    mismatch_count++;
                end
                if (result_if.last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, result_if.last);
                    mismatch_count++;
                end
                if (result_if.char_count !== want.char_count)
                begin
                    $display("%0t: char_count expected %0d actual %0d", $time,
                             want.char_count, result_if.char_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes every so often, from
    // always ready through random and periodic stalls to mostly stalled.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
        end
        stall_mode_left--;
        stall_phase++;
        case (stall_mode)
            0:       result_if.ready <= 1'b1;
            1:       result_if.ready <= 1'($urandom_range(0, 1));
            2:       result_if.ready <= (stall_phase % 5) != 0;
            default: result_if.ready <= (stall_phase % 16) < 4;
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no transfer happens on either side for long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                     $time, idle_cycles, expected_text.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after the
    // request is taken. Valid stays up within a burst, so back-to-back
    // requests go out without a bubble; between bursts it drops for a gap.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [63:0] value, input logic [1:0] action);
        if (burst_left == 0)
        begin
            if (gap_len > 0)
            begin
                item_if.valid = 1'b0;
                repeat (gap_len) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
            // About a third of bursts run without any gap after them
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        item_if.value  = value;
        item_if.action = action;
        item_if.valid  = 1'b1;
        do
            @(posedge clk);
        while (!item_if.ready);
        format_number(value, action);
        burst_left--;
        @(negedge clk);
    endtask

    // Hold off new requests until the block has delivered everything owed
    task automatic wait_for_drain();
        item_if.valid = 1'b0;
        burst_left    = 0;
        while (expected_text.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero prints as a single '0' in every format
    task automatic test_zero();
        send_request(64'd0, ACT_SDEC);
        send_request(64'd0, ACT_UDEC);
        send_request(64'd0, ACT_HEXL);
        send_request(64'd0, ACT_HEXU);
    endtask

    // Largest, smallest and sign-boundary numbers; longest hex strings and
    // every hex letter in both cases
    task automatic test_extremes();
        send_request(64'h0000_0000_7FFF_FFFF, ACT_SDEC);
        send_request(64'h0000_0000_8000_0000, ACT_SDEC);   // most negative, in full
        send_request(64'h0000_0000_FFFF_FFFF, ACT_SDEC);   // -1
        send_request(64'h0000_0000_0000_0001, ACT_SDEC);
        send_request(64'h0000_0000_FFFF_FFFF, ACT_UDEC);
        send_request(64'h0000_0000_8000_0000, ACT_UDEC);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, ACT_HEXL);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, ACT_HEXU);
        send_request(64'h8000_0000_0000_0000, ACT_HEXL);
        send_request(64'hFEDC_BA98_7654_3210, ACT_HEXL);
        send_request(64'hFEDC_BA98_7654_3210, ACT_HEXU);
    endtask

    // Decimal formats must ignore the upper word entirely
    task automatic test_upper_bits_ignored();
        send_request(64'hFFFF_FFFF_0000_0000, ACT_SDEC);
        send_request(64'hDEAD_BEEF_0000_002A, ACT_UDEC);
        send_request(64'h1234_5678_FFFF_FFF6, ACT_SDEC);
    endtask

    // Random numbers across all formats. Values are shaped so digit counts
    // spread out: full random, random bit length, powers of ten and
    // neighbors, and tiny numbers. Halfway the sender waits for a full drain.
    task automatic test_random_requests();
        logic [63:0] value;
        logic [63:0] mask;
        logic [31:0] pow10;
        int          k;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    mask  = {64{1'b1}} >> $urandom_range(0, 63);
                    value = value & mask;
                end
                2:
                begin
                    pow10 = 32'd1;
                    k     = $urandom_range(0, 9);
                    repeat (k) pow10 = pow10 * 32'd10;
                    value = {value[63:32], pow10 - 32'($urandom_range(0, 1))};
                    if ($urandom_range(0, 1) == 1)
                        value[31:0] = -value[31:0];
                end
                default:
                    value = {value[63:32], 32'($urandom_range(0, 20))};
            endcase
            send_request(value, 2'($urandom_range(0, 3)));
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count  = 0;
        burst_left      = 0;
        gap_len         = 0;
        stall_mode      = 0;
        stall_mode_left = 0;
        stall_phase     = 0;
        idle_cycles     = 0;

        item_if.valid   = 1'b0;
        item_if.value   = 64'd0;
        item_if.action  = ACT_SDEC;
        result_if.ready = 1'b0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero();
        test_extremes();
        test_upper_bits_ignored();
        test_random_requests();

        // Let everything come out, then watch for stray characters
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
